// ===== hdl/ffea_pkg.sv =====
// Shared types and codes of the first-fit extent allocator.
package ffea_pkg;

    localparam int REQ_SIZE_W  = 16;
    localparam int SLOT_W      = 5;
    localparam int STATUS_W    = 2;
    localparam int SLOT_FIELD_LIMIT = 32;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CAND_SEL,
        S_CAND_LD,
        S_CAND_CHK,
        S_SCAN,
        S_DRAIN,
        S_CAND_END,
        S_SLOT,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic outer_inc;
        logic cand_zero;
        logic cand_rd;
        logic cand_ld;
        logic scan_clr;
        logic scan_step;
        logic cand_commit;
        logic slot_step;
        logic finish_free;
        logic finish_nospace;
        logic finish_alloc;
        logic finish_noslot;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;
        logic outer_done;
        logic outer_zero;
        logic outer_used;
        logic cand_ok;
        logic scan_last;
        logic found;
        logic slot_free;
        logic out_busy;
    } t_dp_stat;

endpackage

// ===== hdl/ffea_ctrl.sv =====
// Sequencing state machine of the first-fit extent allocator.
module ffea_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ffea_pkg::t_dp_stat i_stat,
    output ffea_pkg::t_dp_cmd  o_cmd
);
    import ffea_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = i_stat.is_free ? S_DONE : S_CAND_SEL;
            end
            S_CAND_SEL: begin
                if (i_stat.outer_done) begin
                    n_state = i_stat.found ? S_SLOT : S_DONE;
                end else if (i_stat.outer_zero) begin
                    n_state = S_CAND_CHK;
                end else if (i_stat.outer_used) begin
                    n_state = S_CAND_LD;
                end
            end
            S_CAND_LD: begin
                n_state = S_CAND_CHK;
            end
            S_CAND_CHK: begin
                n_state = i_stat.cand_ok ? S_SCAN : S_CAND_SEL;
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_CAND_END;
            end
            S_CAND_END: begin
                n_state = S_CAND_SEL;
            end
            S_SLOT: begin
                if (i_stat.slot_free || i_stat.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.finish_free = i_stat.is_free;
            end
            S_CAND_SEL: begin
                if (i_stat.outer_done) begin
                    // The slot search reuses the scan counter.
                    o_cmd.scan_clr       = i_stat.found;
                    o_cmd.finish_nospace = !i_stat.found;
                end else if (i_stat.outer_zero) begin
                    o_cmd.cand_zero = 1'b1;
                end else if (i_stat.outer_used) begin
                    o_cmd.cand_rd = 1'b1;
                end else begin
                    o_cmd.outer_inc = 1'b1;
                end
            end
            S_CAND_LD: begin
                o_cmd.cand_ld = 1'b1;
            end
            S_CAND_CHK: begin
                o_cmd.scan_clr  = i_stat.cand_ok;
                o_cmd.outer_inc = !i_stat.cand_ok;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            S_DRAIN: begin
            end
            S_CAND_END: begin
                o_cmd.cand_commit = 1'b1;
                o_cmd.outer_inc   = 1'b1;
            end
            S_SLOT: begin
                if (i_stat.slot_free) begin
                    o_cmd.finish_alloc = 1'b1;
                end else if (i_stat.scan_last) begin
                    o_cmd.finish_noslot = 1'b1;
                end else begin
                    o_cmd.slot_step = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.out_load = !i_stat.out_busy;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/ffea_dpath.sv =====
// Datapath of the first-fit extent allocator: slot table, candidate test and result register.
module ffea_dpath #(
    parameter int USABLE         = 32,
    parameter int CAPACITY_BYTES = 65536
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ffea_pkg::t_dp_cmd                    i_cmd,
    output ffea_pkg::t_dp_stat                   o_stat,
    input  logic                                 i_command,
    input  logic [ffea_pkg::REQ_SIZE_W-1:0]      i_request_size,
    input  logic [ffea_pkg::SLOT_W-1:0]          i_slot_index,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [ffea_pkg::STATUS_W-1:0]        o_status,
    output logic [ffea_pkg::REQ_SIZE_W-1:0]      o_granted_base,
    output logic [ffea_pkg::SLOT_W-1:0]          o_granted_slot
);
    import ffea_pkg::*;

    localparam int IDX_W = (USABLE > 1) ? $clog2(USABLE) : 1;
    localparam int CNT_W = $clog2(USABLE + 2);
    localparam logic [17:0] CAP = 18'(CAPACITY_BYTES);

    // Each table entry holds the length in the upper half and the base in the lower half.
    logic [31:0] mem [USABLE];

    logic                    r_command;
    logic [REQ_SIZE_W-1:0]   r_size;
    logic [SLOT_W-1:0]       r_slot_in;
    logic [USABLE-1:0]       r_used;
    logic [31:0]             r_rd_a;
    logic [31:0]             r_rd_b;
    logic [CNT_W-1:0]        r_outer;
    logic [CNT_W-1:0]        r_k;
    logic                    r_ev_vld;
    logic [IDX_W-1:0]        r_ev_k;
    logic [16:0]             r_cand;
    logic [17:0]             r_lim;
    logic                    r_blocked;
    logic                    r_found;
    logic [16:0]             r_best;
    logic [STATUS_W-1:0]     r_res_status;
    logic [REQ_SIZE_W-1:0]   r_res_base;
    logic [SLOT_W-1:0]       r_res_slot;
    logic                    r_out_vld;
    logic [STATUS_W-1:0]     r_out_status;
    logic [REQ_SIZE_W-1:0]   r_out_base;
    logic [SLOT_W-1:0]       r_out_slot;

    logic [CNT_W-1:0] outer_m1;
    logic [IDX_W-1:0] outer_idx;
    logic [IDX_W-1:0] k_idx;
    logic [IDX_W-1:0] free_idx;
    logic [17:0]      cand18;
    logic [16:0]      ev_end;
    logic             ev_block;
    logic             free_ok;

    assign outer_m1  = r_outer - CNT_W'(1);
    assign outer_idx = outer_m1[IDX_W-1:0];
    assign k_idx     = r_k[IDX_W-1:0];
    assign free_idx  = r_slot_in[IDX_W-1:0];
    assign cand18    = {1'b0, r_cand};

    // An extent blocks the candidate when it starts before the candidate's end and ends after
    // its start; zero-length extents inside the window block as well.
    assign ev_end   = {1'b0, r_rd_b[15:0]} + {1'b0, r_rd_b[31:16]};
    assign ev_block = ({2'b0, r_rd_b[15:0]} < r_lim) && (ev_end > r_cand);

    assign free_ok = ({1'b0, r_slot_in} < 6'(USABLE)) && r_used[free_idx];

    always_comb begin
        o_stat.is_free    = (r_command == CMD_FREE);
        o_stat.outer_done = (r_outer == CNT_W'(USABLE + 1));
        o_stat.outer_zero = (r_outer == '0);
        o_stat.outer_used = r_used[outer_idx];
        o_stat.cand_ok    = (cand18 < CAP) && ({2'b0, r_size} <= (CAP - cand18))
                            && (!r_found || (r_cand < r_best));
        o_stat.scan_last  = (r_k == CNT_W'(USABLE - 1));
        o_stat.found      = r_found;
        o_stat.slot_free  = !r_used[k_idx];
        o_stat.out_busy   = r_out_vld && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish_alloc) begin
            mem[k_idx] <= {r_size, r_best[15:0]};
        end
        if (i_cmd.cand_rd) begin
            r_rd_a <= mem[outer_idx];
        end
        if (i_cmd.scan_step) begin
            r_rd_b <= mem[k_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_ev_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_ev_vld <= i_cmd.scan_step;
            if (i_cmd.finish_alloc) begin
                r_used[k_idx] <= 1'b1;
            end
            if (i_cmd.finish_free && free_ok) begin
                r_used[free_idx] <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command;
            r_size    <= i_request_size;
            r_slot_in <= i_slot_index;
            r_outer   <= '0;
            r_found   <= 1'b0;
        end
        if (i_cmd.outer_inc) begin
            r_outer <= r_outer + CNT_W'(1);
        end
        if (i_cmd.cand_zero) begin
            r_cand <= '0;
        end
        if (i_cmd.cand_ld) begin
            r_cand <= {1'b0, r_rd_a[15:0]} + {1'b0, r_rd_a[31:16]};
        end
        if (i_cmd.scan_clr) begin
            r_k       <= '0;
            r_blocked <= 1'b0;
            r_lim     <= cand18 + {2'b0, r_size};
        end
        if (i_cmd.scan_step || i_cmd.slot_step) begin
            r_k <= r_k + CNT_W'(1);
        end
        if (i_cmd.scan_step) begin
            r_ev_k <= k_idx;
        end
        if (r_ev_vld && r_used[r_ev_k] && ev_block) begin
            r_blocked <= 1'b1;
        end
        if (i_cmd.cand_commit && !r_blocked) begin
            r_found <= 1'b1;
            r_best  <= r_cand;
        end
        if (i_cmd.finish_free) begin
            r_res_status <= free_ok ? ST_OK : ST_NOT_USED;
            r_res_base   <= '0;
            r_res_slot   <= r_slot_in;
        end
        if (i_cmd.finish_nospace) begin
            r_res_status <= ST_NO_SPACE;
            r_res_base   <= '0;
            r_res_slot   <= '0;
        end
        if (i_cmd.finish_noslot) begin
            r_res_status <= ST_NO_SLOT;
            r_res_base   <= '0;
            r_res_slot   <= '0;
        end
        if (i_cmd.finish_alloc) begin
            r_res_status <= ST_OK;
            r_res_base   <= r_best[15:0];
            r_res_slot   <= SLOT_W'(k_idx);
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_base   <= r_res_base;
            r_out_slot   <= r_res_slot;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_out_status;
    assign o_granted_base = r_out_base;
    assign o_granted_slot = r_out_slot;

endmodule

// ===== hdl/first_fit_extent_allocator.sv =====
// Top level of the first-fit extent allocator.
//
// One command item is worked on at a time. A free's result passes through the result register
// and then the output register. An allocate tests the start of memory and the end of every
// extent in use as a candidate base, and each candidate that fits below the capacity and lies
// below the best base found so far is checked against all table slots, one slot per cycle
// through the table's scan read port. The table has the smaller of SLOT_COUNT and 32 usable
// slots. The lowest free slot is then found by a walk over the used marks. The result waits
// in an output register, and the next command is accepted while it waits. The used marks
// clear at reset; the base and length table needs no clearing.
module first_fit_extent_allocator #(
    parameter int SLOT_COUNT     = 32,
    parameter int CAPACITY_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // request_size[15:0], slot_index[20:16], zero fill
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // granted_base[15:0], granted_slot[20:16], zero fill
    output logic [1:0]  m_axis_tuser    // status
);
    import ffea_pkg::*;

    localparam int USABLE = (SLOT_COUNT < SLOT_FIELD_LIMIT) ? SLOT_COUNT : SLOT_FIELD_LIMIT;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    logic [REQ_SIZE_W-1:0] granted_base;
    logic [SLOT_W-1:0]     granted_slot;

    ffea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    ffea_dpath #(
        .USABLE         (USABLE),
        .CAPACITY_BYTES (CAPACITY_BYTES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_command      (s_axis_tuser),
        .i_request_size (s_axis_tdata[15:0]),
        .i_slot_index   (s_axis_tdata[20:16]),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_status       (m_axis_tuser),
        .o_granted_base (granted_base),
        .o_granted_slot (granted_slot)
    );

    assign m_axis_tdata = {3'b000, granted_slot, granted_base};

endmodule

// ===== hdl/ffea_checker.sv =====
// Port-level assertions of the first-fit extent allocator and their binding.
module ffea_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import ffea_pkg::*;

    // A stalled result item holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result item changed while stalled");

    // Only one command is in work at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a command is in work");

    // A result never appears in the cycle right after a command is taken.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    // Any result other than a granted extent carries a zero base.
    a_fail_base_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata[15:0] == 16'h0000))
        else $error("nonzero base on a result that grants nothing");

    // A failed allocate reports slot zero.
    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && ((m_axis_tuser == ST_NO_SPACE) || (m_axis_tuser == ST_NO_SLOT)))
            |-> (m_axis_tdata[20:16] == 5'd0))
        else $error("nonzero slot on a failed allocate");

endmodule

bind first_fit_extent_allocator ffea_checker u_ffea_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/first_fit_extent_allocator_tb.sv =====
// Self-checking testbench for the first-fit extent allocator: directed table, then random traffic.
`timescale 1ns / 100ps

module first_fit_extent_allocator_tb;
    import ffea_pkg::*;

    localparam int SLOT_COUNT     = 32;
    localparam int CAPACITY_BYTES = 65536;
    localparam int USABLE_SLOTS   =
        (SLOT_COUNT < SLOT_FIELD_LIMIT) ? SLOT_COUNT : SLOT_FIELD_LIMIT;
    localparam int RANDOM_ITEMS   = 500;
    localparam int HOLD_CYCLES    = 3000;
    localparam int SETTLE_CYCLES  = 1500;
    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int N_DIRECTED     = 17;

    typedef struct packed {
        logic                cmd;
        logic [REQ_SIZE_W-1:0] size;
        logic [SLOT_W-1:0]   slot;
    } t_extent_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [REQ_SIZE_W-1:0] base;
        logic [SLOT_W-1:0]     slot;
    } t_extent_reply;

    typedef struct packed {
        t_extent_cmd   cmd;
        logic          has_typed;
        t_extent_reply reply;
    } t_dir_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;

    // Shadow copy of the extent table.
    logic                  tbl_used [SLOT_FIELD_LIMIT];
    logic [REQ_SIZE_W-1:0] tbl_base [SLOT_FIELD_LIMIT];
    logic [REQ_SIZE_W-1:0] tbl_len  [SLOT_FIELD_LIMIT];

    t_extent_reply pending_replies [$];
    int items_sent    = 0;
    int error_count   = 0;
    int cycle_count   = 0;
    int send_idle_pct = 18;
    int recv_idle_pct = 70;
    bit hold_armed    = 1'b0;
    int status_seen [4] = '{0, 0, 0, 0};

    t_dir_row directed_rows [N_DIRECTED] = '{
        // Frees on an empty table.
        '{'{CMD_FREE,  16'h0000, 5'd0},  1'b1, '{ST_NOT_USED, 16'd0, 5'd0}},
        '{'{CMD_FREE,  16'hFFFF, 5'd31}, 1'b1, '{ST_NOT_USED, 16'd0, 5'd31}},
        // Zero-size request, then the largest one, then one byte at the very top.
        '{'{CMD_ALLOC, 16'h0000, 5'd31}, 1'b1, '{ST_OK, 16'd0, 5'd0}},
        '{'{CMD_ALLOC, 16'hFFFF, 5'd0},  1'b1, '{ST_OK, 16'd0, 5'd1}},
        '{'{CMD_ALLOC, 16'h0001, 5'd0},  1'b1, '{ST_OK, 16'hFFFF, 5'd2}},
        // Memory is full to the end.
        '{'{CMD_ALLOC, 16'h0001, 5'd7},  1'b1, '{ST_NO_SPACE, 16'd0, 5'd0}},
        '{'{CMD_ALLOC, 16'h0000, 5'd0},  1'b0, '0},
        '{'{CMD_FREE,  16'h1234, 5'd1},  1'b1, '{ST_OK, 16'd0, 5'd1}},
        '{'{CMD_ALLOC, 16'd100,  5'd0},  1'b0, '0},
        '{'{CMD_ALLOC, 16'd200,  5'd0},  1'b0, '0},
        // Open a hole before the second extent, then fill it exactly.
        '{'{CMD_FREE,  16'h0000, 5'd1},  1'b1, '{ST_OK, 16'd0, 5'd1}},
        '{'{CMD_ALLOC, 16'd60,   5'd0},  1'b0, '0},
        '{'{CMD_ALLOC, 16'd40,   5'd0},  1'b0, '0},
        '{'{CMD_ALLOC, 16'd41,   5'd0},  1'b0, '0},
        '{'{CMD_ALLOC, 16'hFFFF, 5'd0},  1'b1, '{ST_NO_SPACE, 16'd0, 5'd0}},
        '{'{CMD_FREE,  16'h0000, 5'd2},  1'b1, '{ST_OK, 16'd0, 5'd2}},
        '{'{CMD_FREE,  16'h0000, 5'd2},  1'b1, '{ST_NOT_USED, 16'd0, 5'd2}}
    };

    first_fit_extent_allocator #(
        .SLOT_COUNT     (SLOT_COUNT),
        .CAPACITY_BYTES (CAPACITY_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Lowest base that fits, walking used extents in base order (ties by slot index).
    function automatic bit find_first_fit(input int unsigned want,
                                          output logic [REQ_SIZE_W-1:0] at);
        int unsigned order [$];
        int unsigned cursor;
        int unsigned b;
        int unsigned e;
        int i;
        int p;
        cursor = 0;
        at = '0;
        for (i = 0; i < USABLE_SLOTS; i++) begin
            if (tbl_used[i]) begin
                p = order.size();
                while (p > 0 && tbl_base[order[p-1]] > tbl_base[i]) p--;
                order.insert(p, i);
            end
        end
        for (i = 0; i < order.size(); i++) begin
            b = 32'(tbl_base[order[i]]);
            e = b + 32'(tbl_len[order[i]]);
            if (b >= cursor && b - cursor >= want && cursor < CAPACITY_BYTES &&
                want <= CAPACITY_BYTES - cursor) begin
                at = cursor[REQ_SIZE_W-1:0];
                return 1'b1;
            end
            // The cursor only moves forward, so overlaps never give a negative gap.
            if (e > cursor) cursor = e;
        end
        if (cursor < CAPACITY_BYTES && want <= CAPACITY_BYTES - cursor) begin
            at = cursor[REQ_SIZE_W-1:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Applies one command to the shadow table and returns the reply it earns.
    function automatic t_extent_reply apply_extent_cmd(input t_extent_cmd c);
        t_extent_reply r;
        logic [REQ_SIZE_W-1:0] at;
        int i;
        int free_slot;
        r = '{ST_OK, 16'd0, 5'd0};
        if (c.cmd == CMD_ALLOC) begin
            if (!find_first_fit(32'(c.size), at)) begin
                r.status = ST_NO_SPACE;
            end else begin
                free_slot = -1;
                for (i = USABLE_SLOTS - 1; i >= 0; i--)
                    if (!tbl_used[i]) free_slot = i;
                if (free_slot < 0) begin
                    r.status = ST_NO_SLOT;
                end else begin
                    tbl_used[free_slot] = 1'b1;
                    tbl_base[free_slot] = at;
                    tbl_len[free_slot]  = c.size;
                    r.base = at;
                    r.slot = SLOT_W'(free_slot);
                end
            end
        end else begin
            r.slot = c.slot;
            if (c.slot < USABLE_SLOTS && tbl_used[c.slot])
                tbl_used[c.slot] = 1'b0;
            else
                r.status = ST_NOT_USED;
        end
        return r;
    endfunction

    function automatic int slots_in_use();
        int i;
        int n;
        n = 0;
        for (i = 0; i < USABLE_SLOTS; i++)
            if (tbl_used[i]) n++;
        return n;
    endfunction

    function automatic logic [SLOT_W-1:0] pick_used_slot();
        int unsigned used [$];
        int i;
        for (i = 0; i < USABLE_SLOTS; i++)
            if (tbl_used[i]) used.push_back(i);
        if (used.size() == 0) return '0;
        return SLOT_W'(used[$urandom_range(0, used.size() - 1)]);
    endfunction

    // Offers one command item and records its expected reply once accepted.
    task automatic offer(input t_extent_cmd c, input bit has_typed,
                         input t_extent_reply typed_reply);
        t_extent_reply r;
        if (items_sent < 170) begin
            send_idle_pct = 18;
            recv_idle_pct = 70;
        end else if (items_sent < 340) begin
            send_idle_pct = 70;
            recv_idle_pct = 18;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_armed    = 1'b1;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, c.slot, c.size};
        s_axis_tuser  <= c.cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        r = apply_extent_cmd(c);
        if (has_typed) r = typed_reply;
        pending_replies.push_back(r);
        status_seen[r.status]++;
        items_sent++;
    endtask

    // Reply checker and output-side flow control.
    initial begin
        int hold_left;
        bit hold_done;
        t_extent_reply exp_r;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_replies.size() == 0) begin
                    $error("reply with no command outstanding: status %0d, tdata 0x%06h",
                           m_axis_tuser, m_axis_tdata);
                    error_count++;
                end else begin
                    exp_r = pending_replies.pop_front();
                    if (m_axis_tuser !== exp_r.status) begin
                        $error("status: expected %0d, actual %0d", exp_r.status, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata[15:0] !== exp_r.base) begin
                        $error("granted_base: expected %0d, actual %0d",
                               exp_r.base, m_axis_tdata[15:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[20:16] !== exp_r.slot) begin
                        $error("granted_slot: expected %0d, actual %0d",
                               exp_r.slot, m_axis_tdata[20:16]);
                        error_count++;
                    end
                end
            end
            // One long stall lets the block fill up and push back on its input.
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        t_extent_cmd c;
        int i;
        int kind;
        int len;
        int pick;
        bit first_seq;
        for (i = 0; i < SLOT_FIELD_LIMIT; i++) begin
            tbl_used[i] = 1'b0;
            tbl_base[i] = '0;
            tbl_len[i]  = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < N_DIRECTED; i++)
            offer(directed_rows[i].cmd, directed_rows[i].has_typed, directed_rows[i].reply);

        first_seq = 1'b1;
        while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
            kind = first_seq ? 0 : $urandom_range(0, 9);
            first_seq = 1'b0;
            if (kind < 2) begin
                // Fill the table with small extents, then ask for two more slots.
                len = 0;
                while (slots_in_use() < USABLE_SLOTS && len < 40) begin
                    c = '{CMD_ALLOC, 16'($urandom_range(0, 1500)), 5'($urandom_range(0, 31))};
                    offer(c, 1'b0, '0);
                    len++;
                end
                c = '{CMD_ALLOC, 16'h0000, 5'($urandom_range(0, 31))};
                offer(c, 1'b0, '0);
                c = '{CMD_ALLOC, 16'($urandom_range(0, 64)), 5'($urandom_range(0, 31))};
                offer(c, 1'b0, '0);
            end else if (kind < 7) begin
                // Mixed allocates and frees of live slots, occupancy pulled toward half.
                len = $urandom_range(8, 24);
                repeat (len) begin
                    if ($urandom_range(0, USABLE_SLOTS - 1) < slots_in_use()) begin
                        c = '{CMD_FREE, 16'($urandom_range(0, 65535)), pick_used_slot()};
                    end else begin
                        c.cmd  = CMD_ALLOC;
                        c.slot = 5'($urandom_range(0, 31));
                        pick = $urandom_range(0, 9);
                        if (pick < 6)
                            c.size = 16'($urandom_range(0, 4095));
                        else if (pick < 9)
                            c.size = 16'($urandom_range(0, 65535));
                        else
                            c.size = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    end
                    offer(c, 1'b0, '0);
                end
            end else if (kind == 7) begin
                while (slots_in_use() > 0) begin
                    c = '{CMD_FREE, 16'($urandom_range(0, 65535)), pick_used_slot()};
                    offer(c, 1'b0, '0);
                end
            end else begin
                // Stray frees and allocates of any size.
                len = $urandom_range(4, 10);
                repeat (len) begin
                    if ($urandom_range(0, 1))
                        c = '{CMD_FREE, 16'($urandom_range(0, 65535)),
                              5'($urandom_range(0, 31))};
                    else
                        c = '{CMD_ALLOC, 16'($urandom_range(0, 65535)),
                              5'($urandom_range(0, 31))};
                    offer(c, 1'b0, '0);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands under three idling mixes plus one long output stall.",
                 items_sent);
        $display("Replies: %0d ok, %0d no space, %0d no free slot, %0d slot not in use.",
                 status_seen[ST_OK], status_seen[ST_NO_SPACE], status_seen[ST_NO_SLOT],
                 status_seen[ST_NOT_USED]);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ffea_pkg.sv
hdl/ffea_ctrl.sv
hdl/ffea_dpath.sv
hdl/first_fit_extent_allocator.sv
hdl/ffea_checker.sv
dv/first_fit_extent_allocator_tb.sv
